### hw/rtl/mft_pkg.sv
// Shared types and constants of the multicast forwarding table.
package mft_pkg;

  localparam int TableDepth = 32;
  localparam int IfaceCount = 16;
  localparam int SlotW      = $clog2(TableDepth);
  localparam int CntW       = $clog2(TableDepth + 1);
  localparam int IfW        = 4;
  localparam int AddrW      = 48;
  localparam int StampW     = 32;
  localparam int MaxResults = 32;
  localparam int ResW       = $clog2(MaxResults + 1);
  localparam int IterCount  = (IfaceCount < (2 ** IfW)) ? IfaceCount : (2 ** IfW);
  localparam int IterW      = $clog2(IterCount + 1);
  localparam int QueueDepth = 2;

  // Configuration register indexes
  localparam logic [1:0] RegTimeout = 2'd0;
  localparam logic [1:0] RegFanout  = 2'd1;
  localparam logic [1:0] RegCopies  = 2'd2;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_PURGE  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_REFRESHED = 3'd1,
    ST_FULL      = 3'd2,
    ST_FORWARD   = 3'd3,
    ST_NO_ROUTE  = 3'd4,
    ST_PURGED    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_UPD,
    S_PURGE,
    S_EMIT,
    S_NEIGH,
    S_FLUSH
  } eng_state_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] grp;
    logic [AddrW-1:0] org;
    logic [IfW-1:0]   ifn;
    logic [AddrW-1:0] nb;
  } item_t;

  typedef struct packed {
    logic [AddrW-1:0] grp;
    logic [AddrW-1:0] org;
    logic [IfW-1:0]   ifn;
    logic [AddrW-1:0] nb;
  } key_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } fq_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [5:0]  fanout;
    logic [7:0]  copies;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [IfW-1:0]   out_if;
    logic [AddrW-1:0] dest;
    logic             bcast;
    logic [7:0]       copies;
    logic [5:0]       removed;
    logic             last;
  } res_t;

endpackage

### hw/rtl/mft_ram.sv
// Generic single write port RAM with registered read.
module mft_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/mft_front.sv
// Request intake: decode the kind and queue requests for the table engine.
module mft_front import mft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [AddrW-1:0] group_addr_i,
  input  logic [AddrW-1:0] orig_addr_i,
  input  logic [IfW-1:0]   if_index_i,
  input  logic [AddrW-1:0] neigh_addr_i,
  output fq_t              fq_o,
  input  logic             pop_i
);

  localparam int PtrW = $clog2(QueueDepth);
  localparam int QCntW = $clog2(QueueDepth + 1);

  item_t            ent_q [QueueDepth];
  logic [PtrW-1:0]  wp_q, wp_d, rp_q, rp_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  item_t            new_item;
  logic             push, pop;

  // classify the request kind
  always_comb begin
    new_item     = '0;
    new_item.grp = group_addr_i;
    new_item.org = orig_addr_i;
    new_item.ifn = if_index_i;
    new_item.nb  = neigh_addr_i;
    unique case (kind_i)
      OP_UPDATE: new_item.op = OP_UPDATE;
      OP_LOOKUP: new_item.op = OP_LOOKUP;
      OP_PURGE:  new_item.op = OP_PURGE;
      default:   new_item.op = OP_TICK;
    endcase
  end

  assign in_stall_o = (cnt_q == QCntW'(QueueDepth));
  assign push = in_valid_i && !in_stall_o;
  assign pop  = pop_i && (cnt_q != '0);

  // advance pointers
  always_comb begin
    wp_d  = push ? PtrW'(wp_q + 1'b1) : wp_q;
    rp_d  = pop ? PtrW'(rp_q + 1'b1) : rp_q;
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // hold queued requests
  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= new_item;
    end
  end

  assign fq_o.valid = (cnt_q != '0);
  assign fq_o.item  = ent_q[rp_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |=> (cnt_q <= QCntW'(1)))
    else $error("queue count jumped from empty");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == QCntW'(QueueDepth)) |-> in_stall_o)
    else $error("full queue not stalling");

endmodule

### hw/rtl/mft_engine.sv
// Table engine: scan the slots and carry out update, lookup, purge and tick.
module mft_engine import mft_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  fq_t  fq_i,
  output logic pop_o,
  input  logic out_stall_i,
  output res_t res_o
);

  eng_state_e state_q, state_d;
  item_t      cur_q, cur_d;
  logic [StampW-1:0] now_q, now_d;
  logic [TableDepth-1:0] sv_q, sv_d;
  logic [CntW-1:0] sc_q, sc_d;
  logic            pv_q, pv_d;
  logic [SlotW-1:0] pidx_q, pidx_d;
  logic            hit_q, hit_d, free_q, free_d;
  logic [SlotW-1:0] hs_q, hs_d, fs_q, fs_d, sel_q, sel_d;
  logic [CntW-1:0] rm_q, rm_d;
  logic [CntW-1:0] icnt_q [2**IfW];
  logic [CntW-1:0] icnt_d [2**IfW];
  logic [TableDepth-1:0] ml_q, ml_d;
  logic [IfW-1:0]  sif_q [TableDepth];
  logic [IfW-1:0]  sif_d [TableDepth];
  logic [IterW-1:0] i_q, i_d;
  logic [ResW-1:0] n_q, n_d;
  logic            pv_bc_q, pv_bc_d, pend_q, pend_d;
  logic [IfW-1:0]  pend_if_q, pend_if_d;
  logic [AddrW-1:0] pend_dst_q, pend_dst_d;
  res_t            out_q, out_d;

  logic [SlotW-1:0] raddr;
  logic            key_we, stamp_we;
  logic [SlotW-1:0] key_wa, stamp_wa;
  key_t            key_wd, key_rd;
  logic [StampW-1:0] stamp_rd;
  logic            can_push, live, gmatch;
  logic [TableDepth-1:0] cand;
  logic [SlotW-1:0] cand_sel;
  logic            cand_any;

  mft_ram #(.Width($bits(key_t)), .Depth(TableDepth)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .waddr_i(key_wa),
    .wdata_i(key_wd),
    .raddr_i(raddr),
    .rdata_o(key_rd)
  );

  mft_ram #(.Width(StampW), .Depth(TableDepth)) u_stamp_ram (
    .clk_i  (clk_i),
    .we_i   (stamp_we),
    .waddr_i(stamp_wa),
    .wdata_i(now_q),
    .raddr_i(raddr),
    .rdata_o(stamp_rd)
  );

  assign can_push = !out_q.valid || !out_stall_i;
  assign live     = StampW'(now_q - stamp_rd) < StampW'(cfg_i.timeout);
  assign gmatch   = sv_q[pidx_q] && (key_rd.grp == cur_q.grp) && (key_rd.org == cur_q.org);

  // pick the lowest live slot on the current interface
  always_comb begin
    cand_sel = '0;
    cand_any = 1'b0;
    for (int s = 0; s < TableDepth; s++) begin
      cand[s] = ml_q[s] && (sif_q[s] == i_q[IfW-1:0]);
    end
    for (int s = TableDepth - 1; s >= 0; s--) begin
      if (cand[s]) begin
        cand_sel = SlotW'(s);
        cand_any = 1'b1;
      end
    end
  end

  // next state, scan processing and result staging
  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    now_d      = now_q;
    sv_d       = sv_q;
    sc_d       = sc_q;
    pv_d       = 1'b0;
    pidx_d     = pidx_q;
    hit_d      = hit_q;
    free_d     = free_q;
    hs_d       = hs_q;
    fs_d       = fs_q;
    sel_d      = sel_q;
    rm_d       = rm_q;
    icnt_d     = icnt_q;
    ml_d       = ml_q;
    sif_d      = sif_q;
    i_d        = i_q;
    n_d        = n_q;
    pv_bc_d    = pv_bc_q;
    pend_d     = pend_q;
    pend_if_d  = pend_if_q;
    pend_dst_d = pend_dst_q;
    out_d      = out_q;
    if (!out_stall_i) begin
      out_d.valid = 1'b0;
    end
    pop_o    = 1'b0;
    raddr    = sc_q[SlotW-1:0];
    key_we   = 1'b0;
    stamp_we = 1'b0;
    key_wa   = fs_q;
    stamp_wa = hit_q ? hs_q : fs_q;
    key_wd.grp = cur_q.grp;
    key_wd.org = cur_q.org;
    key_wd.ifn = cur_q.ifn;
    key_wd.nb  = cur_q.nb;

    unique case (state_q)
      S_IDLE: begin
        if (fq_i.valid) begin
          pop_o = 1'b1;
          if (fq_i.item.op == OP_TICK) begin
            now_d = now_q + 1'b1;
          end else begin
            cur_d   = fq_i.item;
            state_d = S_SCAN;
            sc_d    = '0;
            hit_d   = 1'b0;
            free_d  = 1'b0;
            rm_d    = '0;
            ml_d    = '0;
            i_d     = '0;
            n_d     = '0;
            pend_d  = 1'b0;
            for (int k = 0; k < 2**IfW; k++) begin
              icnt_d[k] = '0;
            end
          end
        end
      end

      S_SCAN: begin
        // issue one slot read a cycle
        if (sc_q < CntW'(TableDepth)) begin
          sc_d   = sc_q + 1'b1;
          pv_d   = 1'b1;
          pidx_d = sc_q[SlotW-1:0];
        end
        // process the slot read last cycle
        if (pv_q) begin
          unique case (cur_q.op)
            OP_UPDATE: begin
              if (gmatch && key_rd.ifn == cur_q.ifn && key_rd.nb == cur_q.nb && !hit_q) begin
                hit_d = 1'b1;
                hs_d  = pidx_q;
              end
              if (!sv_q[pidx_q] && !free_q) begin
                free_d = 1'b1;
                fs_d   = pidx_q;
              end
            end
            OP_PURGE: begin
              if (sv_q[pidx_q] && !live) begin
                sv_d[pidx_q] = 1'b0;
                rm_d         = rm_q + 1'b1;
              end
            end
            default: begin
              if (gmatch) begin
                icnt_d[key_rd.ifn] = icnt_q[key_rd.ifn] + 1'b1;
              end
              ml_d[pidx_q]  = gmatch && live;
              sif_d[pidx_q] = key_rd.ifn;
            end
          endcase
          if (pidx_q == SlotW'(TableDepth - 1)) begin
            unique case (cur_q.op)
              OP_UPDATE: state_d = S_UPD;
              OP_PURGE:  state_d = S_PURGE;
              default:   state_d = S_EMIT;
            endcase
          end
        end
      end

      S_UPD: begin
        if (can_push) begin
          out_d = '0;
          out_d.valid = 1'b1;
          out_d.last  = 1'b1;
          if (hit_q) begin
            out_d.status = ST_REFRESHED;
            stamp_we     = 1'b1;
          end else if (free_q) begin
            out_d.status = ST_INSERTED;
            stamp_we     = 1'b1;
            key_we       = 1'b1;
            sv_d[fs_q]   = 1'b1;
          end else begin
            out_d.status = ST_FULL;
          end
          state_d = S_IDLE;
        end
      end

      S_PURGE: begin
        if (can_push) begin
          out_d = '0;
          out_d.valid   = 1'b1;
          out_d.last    = 1'b1;
          out_d.status  = ST_PURGED;
          out_d.removed = 6'(rm_q);
          state_d = S_IDLE;
        end
      end

      S_EMIT: begin
        if (n_q == ResW'(MaxResults) || i_q == IterW'(IterCount)) begin
          state_d = S_FLUSH;
        end else if (icnt_q[i_q[IfW-1:0]] == '0) begin
          i_d = i_q + 1'b1;
        end else if (6'(icnt_q[i_q[IfW-1:0]]) > cfg_i.fanout) begin
          if (!pend_q || can_push) begin
            if (pend_q) begin
              out_d = '0;
              out_d.valid  = 1'b1;
              out_d.status = ST_FORWARD;
              out_d.out_if = pend_if_q;
              out_d.dest   = pend_dst_q;
              out_d.bcast  = pv_bc_q;
              out_d.copies = pv_bc_q ? cfg_i.copies : 8'd1;
            end
            pend_d     = 1'b1;
            pv_bc_d    = 1'b1;
            pend_if_d  = i_q[IfW-1:0];
            pend_dst_d = '1;
            n_d        = n_q + 1'b1;
            i_d        = i_q + 1'b1;
          end
        end else if (!cand_any) begin
          i_d = i_q + 1'b1;
        end else begin
          raddr          = cand_sel;
          sel_d          = cand_sel;
          ml_d[cand_sel] = 1'b0;
          state_d        = S_NEIGH;
        end
      end

      S_NEIGH: begin
        raddr = sel_q;
        if (!pend_q || can_push) begin
          if (pend_q) begin
            out_d = '0;
            out_d.valid  = 1'b1;
            out_d.status = ST_FORWARD;
            out_d.out_if = pend_if_q;
            out_d.dest   = pend_dst_q;
            out_d.bcast  = pv_bc_q;
            out_d.copies = pv_bc_q ? cfg_i.copies : 8'd1;
          end
          pend_d     = 1'b1;
          pv_bc_d    = 1'b0;
          pend_if_d  = i_q[IfW-1:0];
          pend_dst_d = key_rd.nb;
          n_d        = n_q + 1'b1;
          state_d    = S_EMIT;
        end
      end

      S_FLUSH: begin
        if (can_push) begin
          out_d = '0;
          out_d.valid = 1'b1;
          out_d.last  = 1'b1;
          if (pend_q) begin
            out_d.status = ST_FORWARD;
            out_d.out_if = pend_if_q;
            out_d.dest   = pend_dst_q;
            out_d.bcast  = pv_bc_q;
            out_d.copies = pv_bc_q ? cfg_i.copies : 8'd1;
          end else begin
            out_d.status = ST_NO_ROUTE;
          end
          pend_d  = 1'b0;
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      now_q   <= '0;
      sv_q    <= '0;
      sc_q    <= '0;
      pv_q    <= 1'b0;
      pend_q  <= 1'b0;
      out_q   <= '0;
      n_q     <= '0;
      i_q     <= '0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      sv_q    <= sv_d;
      sc_q    <= sc_d;
      pv_q    <= pv_d;
      pend_q  <= pend_d;
      out_q   <= out_d;
      n_q     <= n_d;
      i_q     <= i_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    pidx_q     <= pidx_d;
    hit_q      <= hit_d;
    free_q     <= free_d;
    hs_q       <= hs_d;
    fs_q       <= fs_d;
    sel_q      <= sel_d;
    rm_q       <= rm_d;
    icnt_q     <= icnt_d;
    ml_q       <= ml_d;
    sif_q      <= sif_d;
    pv_bc_q    <= pv_bc_d;
    pend_if_q  <= pend_if_d;
    pend_dst_q <= pend_dst_d;
  end

  assign res_o = out_q;

  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("pending result left over in idle");

  a_result_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_q <= ResW'(MaxResults))
    else $error("lookup produced too many results");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_q <= CntW'(TableDepth))
    else $error("scan counter ran past the table");

endmodule

### hw/rtl/multicast_forward_table_aging.sv
// Top level: multicast forwarding table with aging, register port and channels.
// A tick only advances the table time in the engine; update and purge scan the table,
// one table slot read per cycle over 32 slots, and then emit their result.
// After the scan a lookup walks the interfaces and emits its results, the last one flagged.
// The engine takes a new request only once the current one has issued its last result.
// Reset: asynchronous active low; all slots invalid, time zero, registers at defaults.
module multicast_forward_table_aging import mft_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       kind_i,
  input  logic [AddrW-1:0] group_addr_i,
  input  logic [AddrW-1:0] orig_addr_i,
  input  logic [IfW-1:0]   if_index_i,
  input  logic [AddrW-1:0] neigh_addr_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [IfW-1:0]   out_if_o,
  output logic [AddrW-1:0] dest_addr_o,
  output logic             is_broadcast_o,
  output logic [7:0]       copies_o,
  output logic [5:0]       removed_count_o,
  output logic             last_o
);

  cfg_t cfg_q;
  fq_t  fq;
  logic pop;
  res_t res;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout <= 16'd1000;
      cfg_q.fanout  <= 6'd2;
      cfg_q.copies  <= 8'd3;
    end else if (wr_en) begin
      case (paddr[3:2])
        RegTimeout: cfg_q.timeout <= pwdata[15:0];
        RegFanout:  cfg_q.fanout  <= pwdata[5:0];
        RegCopies:  cfg_q.copies  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      RegTimeout: prdata = {16'd0, cfg_q.timeout};
      RegFanout:  prdata = {26'd0, cfg_q.fanout};
      RegCopies:  prdata = {24'd0, cfg_q.copies};
      default:    prdata = '0;
    endcase
  end

  mft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .group_addr_i(group_addr_i),
    .orig_addr_i (orig_addr_i),
    .if_index_i  (if_index_i),
    .neigh_addr_i(neigh_addr_i),
    .fq_o        (fq),
    .pop_i       (pop)
  );

  mft_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .fq_i       (fq),
    .pop_o      (pop),
    .out_stall_i(out_stall_i),
    .res_o      (res)
  );

  assign out_valid_o     = res.valid;
  assign status_o        = res.status;
  assign out_if_o        = res.out_if;
  assign dest_addr_o     = res.dest;
  assign is_broadcast_o  = res.bcast;
  assign copies_o        = res.copies;
  assign removed_count_o = res.removed;
  assign last_o          = res.last;

endmodule
